// File: hdl/adam_pkg.sv
// ---------------------------------------------------------------------------
// adam_pkg
// Shared constants and types of the Adam moment update block.
// ---------------------------------------------------------------------------
package adam_pkg;

    // moment store geometry
    localparam int MOMENT_DEPTH = 4096;
    localparam int SLOT_W       = (MOMENT_DEPTH > 1) ? $clog2(MOMENT_DEPTH) : 1;

    // iteration counts of the pipelined units
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_BETA_ONE          = 3'd0;
    localparam logic [2:0] REG_BETA_TWO          = 3'd1;
    localparam logic [2:0] REG_EPSILON_TERM      = 3'd2;
    localparam logic [2:0] REG_STEP_RATE         = 3'd3;
    localparam logic [2:0] REG_FIRST_CORRECTION  = 3'd4;
    localparam logic [2:0] REG_SECOND_CORRECTION = 3'd5;
    localparam logic [2:0] REG_BATCH_COUNT       = 3'd6;

    // input word
    typedef struct packed {
        logic [11:0]        param_index;
        logic signed [31:0] gradient;
    } adam_in_t;

    // result word
    typedef struct packed {
        logic [11:0]        result_index;
        logic signed [31:0] update_value;
    } adam_out_t;

    // sideband carried through a divider pipeline
    typedef struct packed {
        logic [11:0]       idx;
        logic [SLOT_W-1:0] slot;
        logic              neg;
        logic              ovf;
    } div_tag_t;

    // sideband carried through the root pipeline
    typedef struct packed {
        logic [11:0] idx;
        logic [47:0] mh;
        logic        neg;
    } sqrt_side_t;

    // request into the moment store, one stage before the read returns
    typedef struct packed {
        logic               vld;
        logic [SLOT_W-1:0]  slot;
        logic [11:0]        idx;
        logic signed [49:0] pm;
        logic [48:0]        pv;
    } moment_req_t;

    // updated moments leaving the store
    typedef struct packed {
        logic               vld;
        logic [11:0]        idx;
        logic signed [31:0] m_new;
        logic [31:0]        v_new;
    } moment_rsp_t;

endpackage

// File: hdl/adam_div_pipe.sv
// ---------------------------------------------------------------------------
// adam_div_pipe
// Pipelined restoring divider: 64-bit dividend over 33-bit divisor, one
// quotient bit per stage, 32-bit quotient. The upper dividend half must be
// below the divisor for a valid quotient.
// ---------------------------------------------------------------------------
module adam_div_pipe
    import adam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  logic [63:0] in_num,
    input  logic [32:0] in_den,
    input  div_tag_t    in_tag,
    output logic        out_vld,
    output logic [31:0] out_quot,
    output div_tag_t    out_tag
);

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] low;
        logic [31:0] quot;
        logic [32:0] den;
        div_tag_t    tag;
    } div_stage_t;

    logic       vld_reg [0:DIV_STEPS];
    div_stage_t st_reg  [0:DIV_STEPS];
    div_stage_t st_next [0:DIV_STEPS];

    // one quotient bit per stage
    always_comb
    begin
        logic [33:0] trial;
        logic        ge;
        st_next[0].rem  = {1'b0, in_num[63:32]};
        st_next[0].low  = in_num[31:0];
        st_next[0].quot = '0;
        st_next[0].den  = in_den;
        st_next[0].tag  = in_tag;
        for (int i = 1; i <= DIV_STEPS; i++)
        begin
            trial = {st_reg[i-1].rem, st_reg[i-1].low[31]};
            ge    = (trial >= {1'b0, st_reg[i-1].den});
            st_next[i].rem  = ge ? 33'(trial - {1'b0, st_reg[i-1].den}) : trial[32:0];
            st_next[i].low  = {st_reg[i-1].low[30:0], 1'b0};
            st_next[i].quot = {st_reg[i-1].quot[30:0], ge};
            st_next[i].den  = st_reg[i-1].den;
            st_next[i].tag  = st_reg[i-1].tag;
        end
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DIV_STEPS; i++)
        begin
            st_reg[i] <= st_next[i];
        end
    end

    assign out_vld  = vld_reg[DIV_STEPS];
    assign out_quot = st_reg[DIV_STEPS].quot;
    assign out_tag  = st_reg[DIV_STEPS].tag;

endmodule

// File: hdl/adam_sqrt_pipe.sv
// ---------------------------------------------------------------------------
// adam_sqrt_pipe
// Pipelined integer square root of a 64-bit value, one root bit per stage,
// floor result of 32 bits.
// ---------------------------------------------------------------------------
module adam_sqrt_pipe
    import adam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  logic [63:0] in_x,
    input  sqrt_side_t  in_side,
    output logic        out_vld,
    output logic [31:0] out_root,
    output sqrt_side_t  out_side
);

    typedef struct packed {
        logic [63:0] x;
        logic [31:0] root;
        logic [33:0] rem;
        sqrt_side_t  side;
    } sqrt_stage_t;

    logic        vld_reg [0:SQRT_STEPS];
    sqrt_stage_t st_reg  [0:SQRT_STEPS];
    sqrt_stage_t st_next [0:SQRT_STEPS];

    // one root bit per stage, two radicand bits consumed
    always_comb
    begin
        logic [35:0] cur;
        logic [35:0] trial;
        logic        ge;
        st_next[0].x    = in_x;
        st_next[0].root = '0;
        st_next[0].rem  = '0;
        st_next[0].side = in_side;
        for (int i = 1; i <= SQRT_STEPS; i++)
        begin
            cur   = {st_reg[i-1].rem, st_reg[i-1].x[63:62]};
            trial = {2'b00, st_reg[i-1].root, 2'b01};
            ge    = (cur >= trial);
            st_next[i].rem  = ge ? 34'(cur - trial) : cur[33:0];
            st_next[i].root = {st_reg[i-1].root[30:0], ge};
            st_next[i].x    = {st_reg[i-1].x[61:0], 2'b00};
            st_next[i].side = st_reg[i-1].side;
        end
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SQRT_STEPS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i <= SQRT_STEPS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= SQRT_STEPS; i++)
        begin
            st_reg[i] <= st_next[i];
        end
    end

    assign out_vld  = vld_reg[SQRT_STEPS];
    assign out_root = st_reg[SQRT_STEPS].root;
    assign out_side = st_reg[SQRT_STEPS].side;

endmodule

// File: hdl/adam_moment_store.sv
// ---------------------------------------------------------------------------
// adam_moment_store
// First and second moment memories with read-modify-write, one-deep
// forwarding of the last write, and a clearing pass after reset.
// ---------------------------------------------------------------------------
module adam_moment_store
    import adam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] beta_one,
    input  logic [15:0] beta_two,
    input  moment_req_t req,
    output moment_rsp_t rsp,
    output logic        clearing
);

    logic signed [31:0] m_mem [0:MOMENT_DEPTH-1];
    logic [31:0]        v_mem [0:MOMENT_DEPTH-1];

    logic               clear_reg;
    logic [SLOT_W-1:0]  clr_cnt_reg;

    logic               rmw_vld_reg;
    logic [SLOT_W-1:0]  rmw_slot_reg;
    logic [11:0]        rmw_idx_reg;
    logic signed [49:0] rmw_pm_reg;
    logic [48:0]        rmw_pv_reg;
    logic signed [31:0] rd_m_reg;
    logic [31:0]        rd_v_reg;

    logic               fwd_vld_reg;
    logic [SLOT_W-1:0]  fwd_slot_reg;
    logic signed [31:0] fwd_m_reg;
    logic [31:0]        fwd_v_reg;

    logic               rsp_vld_reg;
    logic [11:0]        rsp_idx_reg;
    logic signed [31:0] rsp_m_reg;
    logic [31:0]        rsp_v_reg;

    logic signed [31:0] m_old;
    logic [31:0]        v_old;
    logic signed [50:0] m_acc;
    logic signed [50:0] m_adj;
    logic signed [31:0] m_new;
    logic [48:0]        v_acc;
    logic [31:0]        v_new;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic signed [31:0] wr_m;
    logic [31:0]        wr_v;

    assign clearing = clear_reg;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_cnt_reg <= SLOT_W'(clr_cnt_reg + 1'b1);
            if (clr_cnt_reg == SLOT_W'(MOMENT_DEPTH - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // update arithmetic with forwarding of the previous write
    always_comb
    begin
        if (fwd_vld_reg && (fwd_slot_reg == rmw_slot_reg))
        begin
            m_old = fwd_m_reg;
            v_old = fwd_v_reg;
        end
        else
        begin
            m_old = rd_m_reg;
            v_old = rd_v_reg;
        end
        m_acc = $signed({1'b0, beta_one}) * m_old + rmw_pm_reg;
        m_adj = m_acc + (m_acc[50] ? 51'sd65535 : 51'sd0);
        m_new = m_adj[47:16];
        v_acc = beta_two * v_old + rmw_pv_reg;
        v_new = v_acc[47:16];
    end

    // write port select
    always_comb
    begin
        wr_en   = clear_reg | rmw_vld_reg;
        wr_addr = clear_reg ? clr_cnt_reg : rmw_slot_reg;
        wr_m    = clear_reg ? '0 : m_new;
        wr_v    = clear_reg ? '0 : v_new;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            m_mem[wr_addr] <= wr_m;
            v_mem[wr_addr] <= wr_v;
        end
        rd_m_reg <= m_mem[req.slot];
        rd_v_reg <= v_mem[req.slot];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmw_vld_reg <= 1'b0;
            fwd_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            rmw_vld_reg <= req.vld;
            rsp_vld_reg <= rmw_vld_reg;
            if (clear_reg)
            begin
                fwd_vld_reg <= 1'b0;
            end
            else if (rmw_vld_reg)
            begin
                fwd_vld_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rmw_slot_reg <= req.slot;
        rmw_idx_reg  <= req.idx;
        rmw_pm_reg   <= req.pm;
        rmw_pv_reg   <= req.pv;
        if (rmw_vld_reg)
        begin
            fwd_slot_reg <= rmw_slot_reg;
            fwd_m_reg    <= m_new;
            fwd_v_reg    <= v_new;
        end
        rsp_idx_reg <= rmw_idx_reg;
        rsp_m_reg   <= m_new;
        rsp_v_reg   <= v_new;
    end

    assign rsp.vld   = rsp_vld_reg;
    assign rsp.idx   = rsp_idx_reg;
    assign rsp.m_new = rsp_m_reg;
    assign rsp.v_new = rsp_v_reg;

endmodule

// File: hdl/adam_moment_update.sv
// ---------------------------------------------------------------------------
// adam_moment_update
// Per-parameter Adam step in Q16.16 fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   A word (param_index, gradient) is taken on a rising edge with start high
//   and busy low. One result word (result_index, update_value) follows on
//   result with done high for exactly one cycle; there is no backpressure.
//   Throughput is one word per cycle while busy is low, set by the moment
//   store: each memory takes one read and one write per cycle, with the
//   previous write forwarded when consecutive words hit the same entry. The
//   gradient divide, the root and the final divide are fully pipelined, one
//   bit per stage. After reset busy stays high while both moment memories
//   are cleared; configuration writes are taken meanwhile. Registers sit on
//   the APB port at byte address 4*index; the user must see that they are
//   written only while no word is in flight, which the block itself does
//   not enforce. Reads return the register value.
// ---------------------------------------------------------------------------
module adam_moment_update
    import adam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  adam_in_t    operand,
    output logic        done,
    output adam_out_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOT_SH = 24;
    localparam int RECIP   = ((1 << SLOT_SH) + MOMENT_DEPTH - 1) / MOMENT_DEPTH;

    // configuration registers
    logic [15:0] beta_one_reg;
    logic [15:0] beta_two_reg;
    logic [15:0] epsilon_term_reg;
    logic [15:0] step_rate_reg;
    logic [31:0] first_correction_reg;
    logic [31:0] second_correction_reg;
    logic [15:0] batch_count_reg;

    logic        accept;
    logic        clearing;
    logic [31:0] in_gmag;
    logic [15:0] batch_eff;
    logic [SLOT_W-1:0] in_slot;
    logic [36:0] slot_prod;
    logic [11:0] slot_quot;
    div_tag_t    d1_tag_in;
    logic        d1_vld;
    logic [31:0] d1_quot;
    div_tag_t    d1_tag;

    logic               p1_vld_reg;
    logic signed [31:0] p1_g_reg;
    logic [31:0]        p1_gmag_reg;
    logic [11:0]        p1_idx_reg;
    logic [SLOT_W-1:0]  p1_slot_reg;
    logic signed [49:0] p1_pm;
    logic [63:0]        p1_gg;
    logic [31:0]        p1_sq;

    logic               p2_vld_reg;
    logic signed [49:0] p2_pm_reg;
    logic [31:0]        p2_sq_reg;
    logic [11:0]        p2_idx_reg;
    logic [SLOT_W-1:0]  p2_slot_reg;
    moment_req_t        mreq;
    moment_rsp_t        mrsp;

    logic [31:0]        p4_mmag;
    logic [63:0]        p4_mh_full;
    logic [63:0]        p4_vh_full;
    logic               p5_vld_reg;
    logic [47:0]        p5_mh_reg;
    logic [47:0]        p5_vh_reg;
    logic               p5_neg_reg;
    logic [11:0]        p5_idx_reg;
    sqrt_side_t         sq_side_in;

    logic               sq_vld;
    logic [31:0]        sq_root;
    sqrt_side_t         sq_side;
    logic [32:0]        den_sum;
    logic [63:0]        num_prod;
    logic               p6_vld_reg;
    logic [63:0]        p6_num_reg;
    logic [32:0]        p6_den_reg;
    logic               p6_neg_reg;
    logic [11:0]        p6_idx_reg;
    div_tag_t           d2_tag_in;

    logic               d2_vld;
    logic [31:0]        d2_quot;
    div_tag_t           d2_tag;
    logic [31:0]        upd;
    logic               done_reg;
    logic [11:0]        res_idx_reg;
    logic [31:0]        res_val_reg;

    // apb register file
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_one_reg          <= 16'd58982;
            beta_two_reg          <= 16'd65470;
            epsilon_term_reg      <= 16'd1;
            step_rate_reg         <= 16'd66;
            first_correction_reg  <= 32'd655360;
            second_correction_reg <= 32'd65536000;
            batch_count_reg       <= 16'd1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                REG_BETA_ONE:          beta_one_reg          <= pwdata[15:0];
                REG_BETA_TWO:          beta_two_reg          <= pwdata[15:0];
                REG_EPSILON_TERM:      epsilon_term_reg      <= pwdata[15:0];
                REG_STEP_RATE:         step_rate_reg         <= pwdata[15:0];
                REG_FIRST_CORRECTION:  first_correction_reg  <= pwdata;
                REG_SECOND_CORRECTION: second_correction_reg <= pwdata;
                REG_BATCH_COUNT:       batch_count_reg       <= pwdata[15:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_BETA_ONE:          prdata = {16'd0, beta_one_reg};
            REG_BETA_TWO:          prdata = {16'd0, beta_two_reg};
            REG_EPSILON_TERM:      prdata = {16'd0, epsilon_term_reg};
            REG_STEP_RATE:         prdata = {16'd0, step_rate_reg};
            REG_FIRST_CORRECTION:  prdata = first_correction_reg;
            REG_SECOND_CORRECTION: prdata = second_correction_reg;
            REG_BATCH_COUNT:       prdata = {16'd0, batch_count_reg};
            default:               prdata = '0;
        endcase
    end

    // input side: magnitude, slot and gradient divide
    assign busy   = clearing;
    assign accept = start && !busy;

    always_comb
    begin
        in_gmag   = operand.gradient[31] ? 32'(-operand.gradient) : operand.gradient;
        batch_eff = (batch_count_reg == 16'd0) ? 16'd1 : batch_count_reg;
        slot_prod = 37'(operand.param_index * 37'(RECIP));
        slot_quot = slot_prod[SLOT_SH +: 12];
        if (MOMENT_DEPTH >= 4096)
        begin
            in_slot = SLOT_W'(operand.param_index);
        end
        else
        begin
            in_slot = SLOT_W'(12'(operand.param_index - 12'(slot_quot * MOMENT_DEPTH)));
        end
        d1_tag_in.idx  = operand.param_index;
        d1_tag_in.slot = in_slot;
        d1_tag_in.neg  = operand.gradient[31];
        d1_tag_in.ovf  = 1'b0;
    end

    adam_div_pipe u_grad_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (accept),
        .in_num   ({32'd0, in_gmag}),
        .in_den   ({17'd0, batch_eff}),
        .in_tag   (d1_tag_in),
        .out_vld  (d1_vld),
        .out_quot (d1_quot),
        .out_tag  (d1_tag)
    );

    // first moment product and gradient square
    always_comb
    begin
        p1_pm = $signed({1'b0, 17'(17'h10000 - {1'b0, beta_one_reg})}) * p1_g_reg;
        p1_gg = p1_gmag_reg * p1_gmag_reg;
        p1_sq = (p1_gg[63:48] != 16'd0) ? 32'hFFFF_FFFF : p1_gg[47:16];
    end

    // second moment product, request to the store
    always_comb
    begin
        mreq.vld  = p2_vld_reg;
        mreq.slot = p2_slot_reg;
        mreq.idx  = p2_idx_reg;
        mreq.pm   = p2_pm_reg;
        mreq.pv   = 17'(17'h10000 - {1'b0, beta_two_reg}) * p2_sq_reg;
    end

    adam_moment_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .beta_one (beta_one_reg),
        .beta_two (beta_two_reg),
        .req      (mreq),
        .rsp      (mrsp),
        .clearing (clearing)
    );

    // bias correction products
    always_comb
    begin
        p4_mmag    = mrsp.m_new[31] ? 32'(-mrsp.m_new) : mrsp.m_new;
        p4_mh_full = p4_mmag * first_correction_reg;
        p4_vh_full = mrsp.v_new * second_correction_reg;
        sq_side_in.idx = p5_idx_reg;
        sq_side_in.mh  = p5_mh_reg;
        sq_side_in.neg = p5_neg_reg;
    end

    adam_sqrt_pipe u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (p5_vld_reg),
        .in_x     ({p5_vh_reg, 16'd0}),
        .in_side  (sq_side_in),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // denominator and numerator of the step
    always_comb
    begin
        den_sum  = {1'b0, sq_root} + {17'd0, epsilon_term_reg};
        num_prod = step_rate_reg * sq_side.mh;
        d2_tag_in.idx  = p6_idx_reg;
        d2_tag_in.slot = '0;
        d2_tag_in.neg  = p6_neg_reg;
        d2_tag_in.ovf  = ({1'b0, p6_num_reg[63:32]} >= p6_den_reg);
    end

    adam_div_pipe u_step_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (p6_vld_reg),
        .in_num   (p6_num_reg),
        .in_den   (p6_den_reg),
        .in_tag   (d2_tag_in),
        .out_vld  (d2_vld),
        .out_quot (d2_quot),
        .out_tag  (d2_tag)
    );

    // sign and saturation
    always_comb
    begin
        if (d2_tag.neg)
        begin
            upd = (d2_tag.ovf || d2_quot[31]) ? 32'h7FFF_FFFF : d2_quot;
        end
        else if (d2_tag.ovf || (d2_quot > 32'h8000_0000))
        begin
            upd = 32'h8000_0000;
        end
        else
        begin
            upd = 32'(-d2_quot);
        end
    end

    // pipeline valids and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= d1_vld;
            p2_vld_reg <= p1_vld_reg;
            p5_vld_reg <= mrsp.vld;
            p6_vld_reg <= sq_vld;
            done_reg   <= d2_vld;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        p1_g_reg    <= d1_tag.neg ? 32'(-d1_quot) : d1_quot;
        p1_gmag_reg <= d1_quot;
        p1_idx_reg  <= d1_tag.idx;
        p1_slot_reg <= d1_tag.slot;
        p2_pm_reg   <= p1_pm;
        p2_sq_reg   <= p1_sq;
        p2_idx_reg  <= p1_idx_reg;
        p2_slot_reg <= p1_slot_reg;
        p5_mh_reg   <= p4_mh_full[63:16];
        p5_vh_reg   <= p4_vh_full[63:16];
        p5_neg_reg  <= mrsp.m_new[31];
        p5_idx_reg  <= mrsp.idx;
        p6_num_reg  <= num_prod;
        p6_den_reg  <= (den_sum == 33'd0) ? 33'd1 : den_sum;
        p6_neg_reg  <= sq_side.neg;
        p6_idx_reg  <= sq_side.idx;
        res_idx_reg <= d2_tag.idx;
        res_val_reg <= upd;
    end

    assign done                = done_reg;
    assign result.result_index = res_idx_reg;
    assign result.update_value = res_val_reg;

endmodule

// File: sim/adam_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adam_checker
// Watches the config port and both word channels of adam_moment_update,
// models the fixed-point Adam step with its own moment stores and registers,
// and compares every result word with the oldest predicted one.
// ---------------------------------------------------------------------------
module adam_checker
    import adam_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  adam_in_t  operand,
    input  logic      done,
    input  adam_out_t result,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic [4:0] paddr,
    input  logic [31:0] pwdata,
    input  logic      pready,
    output int        errors,
    output int        outstanding,
    output int        words_checked
);

    // mirrored registers
    logic [15:0] b1_q, b2_q, eps_q, lr_q, bc_q;
    logic [31:0] fc_q, sc_q;

    // mirrored moment stores
    logic [31:0] m_store [MOMENT_DEPTH];
    logic [31:0] v_store [MOMENT_DEPTH];

    adam_out_t update_q[$];

    // integer square root, floor
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // one adam step: updates the stores and returns the expected word
    function automatic adam_out_t adam_step(input adam_in_t w);
        int unsigned slot;
        longint      grad, dv, g, m_old, acc, m_new;
        logic [63:0] gmag, sq, vacc, v_new, mmag, mh, vh, d, q;
        logic        neg;
        adam_out_t   r;
        slot  = w.param_index % MOMENT_DEPTH;
        grad  = longint'(w.gradient);
        dv    = (bc_q == 0) ? 1 : longint'(bc_q);
        g     = grad / dv;
        // first moment
        m_old = longint'($signed(m_store[slot]));
        acc   = longint'(b1_q) * m_old + (65536 - longint'(b1_q)) * g;
        m_new = acc / 65536;
        m_store[slot] = m_new[31:0];
        // second moment
        gmag = (g < 0) ? -g : g;
        sq   = (gmag * gmag) >> 16;
        if (sq > 64'hFFFF_FFFF)
            sq = 64'hFFFF_FFFF;
        vacc  = 64'(b2_q) * 64'(v_store[slot]) + (64'd65536 - 64'(b2_q)) * sq;
        v_new = vacc >> 16;
        v_store[slot] = v_new[31:0];
        // bias correction and step
        neg  = m_new < 0;
        mmag = neg ? -m_new : m_new;
        mh   = (mmag * 64'(fc_q)) >> 16;
        vh   = (v_new * 64'(sc_q)) >> 16;
        d    = isqrt64(vh << 16) + 64'(eps_q);
        if (d == 0)
            d = 1;
        q = (64'(lr_q) * mh) / d;
        r.result_index = w.param_index;
        if (neg)
        begin
            if (q > 64'h7FFF_FFFF)
                q = 64'h7FFF_FFFF;
            r.update_value = q[31:0];
        end
        else
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            r.update_value = 32'd0 - q[31:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        adam_out_t exp_w;
        if (!rst_n)
        begin
            b1_q  <= 16'd58982;
            b2_q  <= 16'd65470;
            eps_q <= 16'd1;
            lr_q  <= 16'd66;
            fc_q  <= 32'd655360;
            sc_q  <= 32'd65536000;
            bc_q  <= 16'd1;
            for (int i = 0; i < MOMENT_DEPTH; i++)
            begin
                m_store[i] = 0;
                v_store[i] = 0;
            end
            update_q.delete();
            errors        <= 0;
            words_checked <= 0;
            outstanding   <= 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_BETA_ONE:          b1_q  <= pwdata[15:0];
                    REG_BETA_TWO:          b2_q  <= pwdata[15:0];
                    REG_EPSILON_TERM:      eps_q <= pwdata[15:0];
                    REG_STEP_RATE:         lr_q  <= pwdata[15:0];
                    REG_FIRST_CORRECTION:  fc_q  <= pwdata;
                    REG_SECOND_CORRECTION: sc_q  <= pwdata;
                    REG_BATCH_COUNT:       bc_q  <= pwdata[15:0];
                    default: ;
                endcase
            end
            // result words against the oldest prediction
            if (done)
            begin
                if (update_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result word idx=%0d val=%0d",
                                 result.result_index, result.update_value);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_w = update_q.pop_front();
                    words_checked <= words_checked + 1;
                    if (exp_w.result_index !== result.result_index ||
                        exp_w.update_value !== result.update_value)
                    begin
                        if (errors < 10)
                            $display("mismatch: exp idx=%0d val=%0d got idx=%0d val=%0d",
                                     exp_w.result_index, exp_w.update_value,
                                     result.result_index, result.update_value);
                        errors <= errors + 1;
                    end
                end
            end
            // accepted input words
            if (start && !busy)
                update_q.push_back(adam_step(operand));
            // words still awaiting a result
            outstanding <= update_q.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for adam_moment_update: directed edge cases, then random phases
// under several register settings and sender idle rates.
// ---------------------------------------------------------------------------
module tb;
    import adam_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    adam_in_t    operand;
    logic        done;
    adam_out_t   result;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          errors, outstanding, words_checked;
    int          idle_pct;
    int          sent;
    longint      cycles;

    adam_moment_update dut (.*);

    adam_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .operand(operand),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .errors(errors), .outstanding(outstanding), .words_checked(words_checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // apb write, setup then access
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_regs(input logic [15:0] b1, input logic [15:0] b2,
                             input logic [15:0] eps, input logic [15:0] lr,
                             input logic [31:0] fc, input logic [31:0] sc,
                             input logic [15:0] bc);
        reg_write(REG_BETA_ONE, {16'hA5A5, b1});
        reg_write(REG_BETA_TWO, {16'd0, b2});
        reg_write(REG_EPSILON_TERM, {16'd0, eps});
        reg_write(REG_STEP_RATE, {16'd0, lr});
        reg_write(REG_FIRST_CORRECTION, fc);
        reg_write(REG_SECOND_CORRECTION, sc);
        reg_write(REG_BATCH_COUNT, {16'd0, bc});
    endtask

    // send one word, with a random idle gap in front
    task automatic send_word(input logic [11:0] idx, input logic [31:0] grad);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        operand <= '{param_index: idx, gradient: grad};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // let every result drain, then cover the pipeline depth
    task automatic drain();
        start <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_grad();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2:       return 32'($signed($urandom_range(2000)) - 1000);
            default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
        endcase
    endfunction

    task automatic random_words(input int n);
        logic [11:0] idx;
        for (int i = 0; i < n; i++)
        begin
            // mostly a small hot set so moments build up and repeat back to back
            idx = ($urandom_range(99) < 60) ? 12'($urandom_range(7)) : 12'($urandom());
            send_word(idx, rand_grad());
            if (i == n / 2 && $urandom_range(1))
                drain();
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        operand  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_pct = 0;
        sent     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words under reset settings
        send_word(12'd0, 32'h7FFF_FFFF);
        send_word(12'd0, 32'h8000_0000);
        send_word(12'd4095, 32'h8000_0000);
        send_word(12'd4095, 32'h7FFF_FFFF);
        send_word(12'd1, 32'd0);
        send_word(12'd2, 32'd1);
        send_word(12'd2, 32'hFFFF_FFFF);
        send_word(12'hAAA, 32'h0001_0000);
        send_word(12'h555, 32'hFFFF_0000);
        send_word(12'h555, 32'hFFFF_0000);
        drain();

        // zero batch count, zero epsilon with zero root, write past the list
        reg_write(3'd7, 32'hFFFF_FFFF);
        load_regs(16'd0, 16'd0, 16'd0, 16'd65535, 32'd65536, 32'd65536, 16'd0);
        send_word(12'd100, 32'd0);
        send_word(12'd101, 32'h0000_8000);
        send_word(12'd101, 32'hFFF0_0000);
        send_word(12'd102, 32'h7FFF_FFFF);
        send_word(12'd103, 32'h8000_0000);
        random_words(300);
        drain();

        // upper extremes, sender idle most cycles
        idle_pct = 82;
        load_regs(16'd65535, 16'd65535, 16'd65535, 16'd0, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 16'd65535);
        random_words(300);
        drain();

        // corrections below one, large step
        idle_pct = 0;
        load_regs(16'd58982, 16'd65470, 16'd1, 16'd65535, 32'd100, 32'd5, 16'd3);
        send_word(12'd7, 32'h7FFF_FFFF);
        send_word(12'd7, 32'h8000_0000);
        random_words(300);
        drain();

        // random settings, various idle rates
        for (int p = 0; p < 3; p++)
        begin
            idle_pct = (p == 0) ? 18 : ((p == 1) ? 82 : 0);
            load_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                      16'($urandom()), $urandom(), $urandom(),
                      16'($urandom_range(8)));
            random_words(320);
            drain();
        end

        // full wait for the idle queue with a bound
        while (outstanding != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        $display("run covered %0d words under seven register settings", sent);
        $display("%0d result words compared, sender idle rates 0/18/82", words_checked);
        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
